### rtl/core/depth_grid_mesh_triangulator_unit_assert.svh
// Assertion macros for the depth grid mesh triangulator.
`ifndef DEPTH_GRID_MESH_TRIANGULATOR_UNIT_ASSERT_SVH
`define DEPTH_GRID_MESH_TRIANGULATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge of clk while rstn is high.
`define DGMT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("depth grid mesh triangulator: assertion failed");
// Check a property on every rising edge of clk, reset included.
`define DGMT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("depth grid mesh triangulator: assertion failed");
`else
`define DGMT_ASSERT(lbl, clk, rstn, prop)
`define DGMT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/core/dgmt_pkg.sv
// Types, constants and register codes of the depth grid mesh triangulator.
`default_nettype none

package dgmt_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int COORD_W  = 32;
    localparam int SIZE_W   = 12;
    localparam int IDX_W    = 22;
    localparam int KEPT_W   = 23;
    localparam int ENTRY_W  = IDX_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [SIZE_W-1:0]         FRAME_WIDTH_RST  = 12'd640;
    localparam logic [SIZE_W-1:0]         FRAME_HEIGHT_RST = 12'd480;
    localparam logic signed [COORD_W-1:0] Z_LOW_RST        = 32'sh0000_0000;
    localparam logic signed [COORD_W-1:0] Z_HIGH_RST       = 32'sh7FFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_Z_LOW        = 2'd2,
        CFG_Z_HIGH       = 2'd3
    } cfg_index_t;

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // One-hot result slots of a point, in emission order.
    localparam logic [2:0] SLOT_VERTEX     = 3'b001;
    localparam logic [2:0] SLOT_TRI_TOP    = 3'b010;
    localparam logic [2:0] SLOT_TRI_BOTTOM = 3'b100;

    // Line buffer entry: mesh index plus kept flag.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } mesh_entry_t;

endpackage

`default_nettype wire

### rtl/core/depth_grid_mesh_triangulator_unit.sv
// Top level of the depth grid mesh triangulator: filter, index, line buffer, triangle emit.
`default_nettype none
`include "depth_grid_mesh_triangulator_unit_assert.svh"

// Points of an organized depth grid arrive in raster order, one transaction each.
// A point whose z lies strictly between z_low and z_high is kept, gets the next
// mesh index and leaves as a vertex record; when it closes a grid cell whose
// top-right and bottom-left corners are kept, up to two triangle records follow.
// A point produces zero to three result transactions, the last one flagged by
// m_last_of_item. A point enters every cycle while each point makes at most one
// result and m_ready is high; a point with more results holds the input until
// its last result enters the single output register, which hands out one result
// per cycle while m_ready is high. Results pass the line buffer read, then the
// output register. The line buffer is a MAX_WIDTH-entry RAM read and written
// once per point at its column; it is not cleared after reset, so no clearing
// pass runs. Frame sizes are clamped to [2, MAX_WIDTH] and [2, MAX_HEIGHT].
// Write configuration only while no transaction is in flight.
module depth_grid_mesh_triangulator_unit
    import dgmt_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration
    input  wire logic                        cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]        cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]       cfg_wr_data,
    // point input
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [COORD_W-1:0]   s_point_x,
    input  wire logic signed [COORD_W-1:0]   s_point_y,
    input  wire logic signed [COORD_W-1:0]   s_point_z,
    // result output
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_kind,
    output logic signed [COORD_W-1:0]        m_vertex_x,
    output logic signed [COORD_W-1:0]        m_vertex_y,
    output logic signed [COORD_W-1:0]        m_vertex_z,
    output logic        [IDX_W-1:0]          m_source_index,
    output logic        [IDX_W-1:0]          m_corner_a,
    output logic        [IDX_W-1:0]          m_corner_b,
    output logic        [IDX_W-1:0]          m_corner_c,
    output logic                             m_last_of_item
);

    localparam int CW = $clog2(MAX_WIDTH + 1);   // column count, holds the width
    localparam int RW = $clog2(MAX_HEIGHT + 1);  // row count, holds the height
    localparam int AW = $clog2(MAX_WIDTH);       // line buffer address
    localparam int PW = CW + RW + 1;             // raster product

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic        [SIZE_W-1:0]  frame_width_reg;
    logic        [SIZE_W-1:0]  frame_height_reg;
    logic signed [COORD_W-1:0] z_low_reg;
    logic signed [COORD_W-1:0] z_high_reg;

    logic [CW-1:0] width;
    logic [RW-1:0] height;

    // Clamp the size registers to the supported range.
    always_comb begin
        if (int'(frame_width_reg) > MAX_WIDTH) begin
            width = CW'(MAX_WIDTH);
        end else if (frame_width_reg < SIZE_W'(2)) begin
            width = CW'(2);
        end else begin
            width = CW'(frame_width_reg);
        end
        if (int'(frame_height_reg) > MAX_HEIGHT) begin
            height = RW'(MAX_HEIGHT);
        end else if (frame_height_reg < SIZE_W'(2)) begin
            height = RW'(2);
        end else begin
            height = RW'(frame_height_reg);
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: raster position, keep test, mesh index, line buffer access
    // ---------------------------------------------------------------
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [KEPT_W-1:0] kept_reg, kept_next;

    logic [CW-1:0]     pos_x;
    logic [RW-1:0]     pos_y;
    logic [KEPT_W-1:0] kept_base;
    logic              point_kept;
    mesh_entry_t       cur_entry;
    logic              s_accept;

    assign s_accept = s_valid && s_ready;

    always_comb begin
        pos_x     = col_reg;
        pos_y     = row_reg;
        kept_base = kept_reg;
        // Height shrunk under a running frame: restart the frame.
        if (pos_y >= height) begin
            pos_y     = '0;
            pos_x     = '0;
            kept_base = '0;
        end
        // Width shrunk under a running row: close the row first.
        if (pos_x >= width) begin
            pos_x = '0;
            pos_y = RW'(pos_y + 1'b1);
            if (pos_y >= height) begin
                pos_y     = '0;
                kept_base = '0;
            end
        end

        point_kept      = (s_point_z > z_low_reg) && (s_point_z < z_high_reg);
        cur_entry.valid = point_kept;
        cur_entry.index = kept_base[IDX_W-1:0];

        kept_next = point_kept ? KEPT_W'(kept_base + 1'b1) : kept_base;
        col_next  = CW'(pos_x + 1'b1);
        row_next  = pos_y;
        // Advance to the next row, and past the last row to a new frame.
        if (col_next >= width) begin
            col_next = '0;
            row_next = RW'(pos_y + 1'b1);
            if (row_next >= height) begin
                row_next  = '0;
                kept_next = '0;
            end
        end
    end

    // Line buffer: the row above's mesh entry at each column.
    logic [ENTRY_W-1:0] above_word;

    dgmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (pos_x[AW-1:0]),
        .wr_data (cur_entry),
        .rd_en   (s_accept),
        .rd_addr (pos_x[AW-1:0]),
        .rd_data (above_word)
    );

    // ---------------------------------------------------------------
    // Stage 1: cell test and result sequencing
    // ---------------------------------------------------------------
    logic                      s1_valid_reg;
    logic [CW-1:0]             s1_x_reg;
    logic [RW-1:0]             s1_y_reg;
    mesh_entry_t               s1_cur_reg;
    logic signed [COORD_W-1:0] s1_px_reg;
    logic signed [COORD_W-1:0] s1_py_reg;
    logic signed [COORD_W-1:0] s1_pz_reg;
    mesh_entry_t               prev_tr_reg;   // becomes top-left of the next cell
    mesh_entry_t               prev_cur_reg;  // becomes bottom-left of the next cell
    logic [2:0]                sent_reg;

    mesh_entry_t tr_entry;
    logic        cell_ok;
    logic [2:0]  slot_mask;
    logic [2:0]  pend;
    logic [2:0]  pick;
    logic [2:0]  rem;
    logic        out_free;
    logic        emit;
    logic        s1_done;
    logic [PW-1:0]    raster;
    logic [IDX_W-1:0] source_idx;

    logic                      m_valid_reg;
    logic                      m_kind_reg;
    logic signed [COORD_W-1:0] m_vertex_x_reg;
    logic signed [COORD_W-1:0] m_vertex_y_reg;
    logic signed [COORD_W-1:0] m_vertex_z_reg;
    logic [IDX_W-1:0]          m_source_index_reg;
    logic [IDX_W-1:0]          m_corner_a_reg;
    logic [IDX_W-1:0]          m_corner_b_reg;
    logic [IDX_W-1:0]          m_corner_c_reg;
    logic                      m_last_reg;

    always_comb begin
        tr_entry  = mesh_entry_t'(above_word);
        cell_ok   = (s1_y_reg != '0) && (s1_x_reg != '0)
                    && tr_entry.valid && prev_cur_reg.valid;
        slot_mask = {cell_ok && s1_cur_reg.valid,
                     cell_ok && prev_tr_reg.valid,
                     s1_cur_reg.valid};
        pend      = slot_mask & ~sent_reg;
        pick      = pend & (~pend + 3'd1);      // lowest pending slot
        out_free  = !m_valid_reg || m_ready;
        emit      = s1_valid_reg && out_free && (pend != '0);
        rem       = emit ? (pend & ~pick) : pend;
        s1_done   = s1_valid_reg && (rem == '0);
        raster    = PW'(s1_y_reg) * PW'(width) + PW'(s1_x_reg);
        source_idx = IDX_W'(raster);
    end

    // Take a new point when stage 1 is empty or retires its point this cycle.
    assign s_ready = !s1_valid_reg || s1_done;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            z_low_reg        <= Z_LOW_RST;
            z_high_reg       <= Z_HIGH_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            kept_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            sent_reg         <= '0;
            prev_tr_reg      <= '0;
            prev_cur_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_addr))
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data[SIZE_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[SIZE_W-1:0];
                    CFG_Z_LOW:        z_low_reg        <= signed'(cfg_wr_data);
                    CFG_Z_HIGH:       z_high_reg       <= signed'(cfg_wr_data);
                    default: ;
                endcase
            end

            if (s_accept) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                kept_reg <= kept_next;
            end

            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_done) begin
                s1_valid_reg <= 1'b0;
            end

            // Drop the sent marks when the point retires.
            if (s1_done) begin
                sent_reg     <= '0;
                prev_tr_reg  <= tr_entry;
                prev_cur_reg <= s1_cur_reg;
            end else if (emit) begin
                sent_reg <= sent_reg | pick;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_x_reg   <= pos_x;
            s1_y_reg   <= pos_y;
            s1_cur_reg <= cur_entry;
            s1_px_reg  <= s_point_x;
            s1_py_reg  <= s_point_y;
            s1_pz_reg  <= s_point_z;
        end

        if (emit) begin
            m_last_reg <= (rem == '0);
            unique case (pick)
                SLOT_VERTEX: begin
                    m_kind_reg         <= KIND_VERTEX;
                    m_vertex_x_reg     <= s1_px_reg;
                    m_vertex_y_reg     <= s1_py_reg;
                    m_vertex_z_reg     <= s1_pz_reg;
                    m_source_index_reg <= source_idx;
                    m_corner_a_reg     <= '0;
                    m_corner_b_reg     <= '0;
                    m_corner_c_reg     <= '0;
                end
                SLOT_TRI_TOP: begin
                    m_kind_reg         <= KIND_TRIANGLE;
                    m_vertex_x_reg     <= '0;
                    m_vertex_y_reg     <= '0;
                    m_vertex_z_reg     <= '0;
                    m_source_index_reg <= '0;
                    m_corner_a_reg     <= prev_tr_reg.index;
                    m_corner_b_reg     <= prev_cur_reg.index;
                    m_corner_c_reg     <= tr_entry.index;
                end
                SLOT_TRI_BOTTOM: begin
                    m_kind_reg         <= KIND_TRIANGLE;
                    m_vertex_x_reg     <= '0;
                    m_vertex_y_reg     <= '0;
                    m_vertex_z_reg     <= '0;
                    m_source_index_reg <= '0;
                    m_corner_a_reg     <= tr_entry.index;
                    m_corner_b_reg     <= prev_cur_reg.index;
                    m_corner_c_reg     <= s1_cur_reg.index;
                end
                default: begin
                    m_kind_reg         <= KIND_VERTEX;
                    m_vertex_x_reg     <= '0;
                    m_vertex_y_reg     <= '0;
                    m_vertex_z_reg     <= '0;
                    m_source_index_reg <= '0;
                    m_corner_a_reg     <= '0;
                    m_corner_b_reg     <= '0;
                    m_corner_c_reg     <= '0;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_vertex_x     = m_vertex_x_reg;
    assign m_vertex_y     = m_vertex_y_reg;
    assign m_vertex_z     = m_vertex_z_reg;
    assign m_source_index = m_source_index_reg;
    assign m_corner_a     = m_corner_a_reg;
    assign m_corner_b     = m_corner_b_reg;
    assign m_corner_c     = m_corner_c_reg;
    assign m_last_of_item = m_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Hold the line buffer word while a point waits in stage 1.
    `DGMT_ASSERT(a_above_word_held, aclk, aresetn,
                 s1_valid_reg && !s1_done |=> $stable(above_word))
    // Sent marks only cover slots the point actually has.
    `DGMT_ASSERT(a_sent_in_mask, aclk, aresetn,
                 s1_valid_reg |-> ((sent_reg & ~slot_mask) == 3'b000))
    // A new result appears only out of an occupied stage 1.
    `DGMT_ASSERT(a_result_from_point, aclk, aresetn,
                 $rose(m_valid_reg) |-> $past(s1_valid_reg))
    // Sent marks are empty whenever stage 1 holds no point.
    `DGMT_ASSERT_ALWAYS(a_sent_idle, aclk,
                        !s1_valid_reg |-> (sent_reg == 3'b000))

endmodule

`default_nettype wire

### rtl/core/dgmt_ram.sv
// Generic simple dual-port RAM with registered, read-first output.
`default_nettype none

module dgmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Same-address read and write return the old word.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
